FILE: design/wrm_pkg.sv
package wrm_pkg;

   localparam int SCORE_DEPTH_DEFAULT = 8;

   localparam int VALUE_W  = 48;
   localparam int TIME_W   = 32;
   localparam int AMOUNT_W = 32;
   localparam int IVL_W    = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // register index, byte address is 4 * index
   localparam logic [CSR_ADDR_W-3:0] REG_INTERVAL_TICKS = '0;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_U_START,
      ST_U_ROLL,
      ST_U_ZLOOP,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_Q_SETUP,
      ST_Q_CHECK,
      ST_DIV,
      ST_DIV_END,
      ST_OUT
   } wrm_state_type;

endpackage

FILE: design/wrm_ram.sv
module wrm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/windowed_rate_meter_unit.sv
// update without rollover: U_START, U_ROLL, OUT; a stale query: Q_SETUP, Q_CHECK, OUT
// update with rollover: U_ZLOOP, PUSH_RD, PUSH_WR per zero slot and for the last slot,
// one ring read and write per slot; query: 48 + clog2(SCORE_DEPTH + 1) numerator bits,
// one quotient bit per cycle from the shared subtract/compare unit; the next transaction
// is taken at the earliest in the same cycle as its result, and only one is held at a time
// synchronous reset: counters and ring valid bits clear at once, interval_ticks returns to 1
module windowed_rate_meter_unit
   import wrm_pkg::*;
#(
   parameter int SCORE_DEPTH = SCORE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [TIME_W-1:0]     req_now_time,
   input  logic [AMOUNT_W-1:0]   req_amount,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_value,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SCORE_DEPTH + 2);
   localparam int SUM_W  = VALUE_W + $clog2(SCORE_DEPTH);
   localparam int NUM_W  = VALUE_W + $clog2(SCORE_DEPTH + 1);
   localparam int DIV_W  = IVL_W + $clog2(SCORE_DEPTH + 1);
   localparam int ALU_W  = (DIV_W + 1 > TIME_W) ? DIV_W + 1 : TIME_W;
   localparam int WS_W   = ((DIV_W > TIME_W) ? DIV_W : TIME_W) + 1;
   localparam int DCNT_W = $clog2(NUM_W);

   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SCORE_DEPTH + 1);
   localparam logic [CNT_W-1:0] ZERO_MAX  = CNT_W'(SCORE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SCORE_DEPTH - 1);
   localparam logic [DIV_W-1:0] WIN_SLOTS = DIV_W'(SCORE_DEPTH + 1);

   wrm_state_type state_ff, state_in;

   logic [IVL_W-1:0]    interval_ff, interval_in;
   logic [VALUE_W-1:0]  current_ff, current_in;
   logic [VALUE_W-1:0]  previous_ff, previous_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [CNT_W-1:0]    upd_cnt_ff, upd_cnt_in;
   logic [SCORE_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [IDX_W-1:0]    widx_ff, widx_in;
   logic [SUM_W-1:0]    ring_sum_ff, ring_sum_in;

   logic [TIME_W-1:0]   now_ff, now_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;

   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]    zcnt_ff, zcnt_in;
   logic [VALUE_W-1:0]  push_val_ff, push_val_in;
   logic                push_final_ff, push_final_in;
   logic [DIV_W-1:0]    window_ff, window_in;
   logic [DIV_W-1:0]    prod_ff, prod_in;
   logic [DIV_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_W-1:0]    drem_ff, drem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [VALUE_W-1:0]  result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   // shared subtract and compare unit
   logic [ALU_W-1:0]    alu_a, alu_b;
   logic [ALU_W:0]      alu_diff;
   logic                alu_ge;

   logic [IVL_W-1:0]    ivl_eff;
   logic [VALUE_W:0]    acc_sum;
   logic [VALUE_W-1:0]  old_slot;
   logic [DIV_W:0]      trial;
   logic [WS_W-1:0]     stale_limit;
   logic                stale;
   logic [DIV_W-1:0]    div_sel;
   logic                csr_wr;
   logic [VALUE_W-1:0]  ram_rdata;

   assign ivl_eff = (interval_ff == '0) ? IVL_W'(1) : interval_ff;

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[ALU_W];

   assign trial       = {drem_ff, quo_ff[NUM_W-1]};
   assign acc_sum     = {1'b0, current_ff} + {{(VALUE_W + 1 - AMOUNT_W){1'b0}}, amt_ff};
   assign old_slot    = slot_valid_ff[widx_ff] ? ram_rdata : '0;
   assign stale_limit = WS_W'(last_ff) + WS_W'(window_ff);
   assign stale       = WS_W'(now_ff) > stale_limit;
   assign div_sel     = (upd_cnt_ff < CNT_FULL) ? prod_ff : window_ff;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   wrm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (SCORE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_PUSH_WR),
      .wr_addr (widx_ff),
      .wr_data (push_val_ff),
      .rd_en   (state_ff == ST_PUSH_RD),
      .rd_addr (widx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         interval_ff   <= IVL_W'(1);
         current_ff    <= '0;
         previous_ff   <= '0;
         last_ff       <= '0;
         upd_cnt_ff    <= '0;
         slot_valid_ff <= '0;
         widx_ff       <= '0;
         ring_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         interval_ff   <= interval_in;
         current_ff    <= current_in;
         previous_ff   <= previous_in;
         last_ff       <= last_in;
         upd_cnt_ff    <= upd_cnt_in;
         slot_valid_ff <= slot_valid_in;
         widx_ff       <= widx_in;
         ring_sum_ff   <= ring_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      amt_ff        <= amt_in;
      rem_ff        <= rem_in;
      zcnt_ff       <= zcnt_in;
      push_val_ff   <= push_val_in;
      push_final_ff <= push_final_in;
      window_ff     <= window_in;
      prod_ff       <= prod_in;
      divisor_ff    <= divisor_in;
      drem_ff       <= drem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      result_ff     <= result_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_comb begin
      state_in      = state_ff;
      interval_in   = interval_ff;
      current_in    = current_ff;
      previous_in   = previous_ff;
      last_in       = last_ff;
      upd_cnt_in    = upd_cnt_ff;
      slot_valid_in = slot_valid_ff;
      widx_in       = widx_ff;
      ring_sum_in   = ring_sum_ff;
      now_in        = now_ff;
      amt_in        = amt_ff;
      rem_in        = rem_ff;
      zcnt_in       = zcnt_ff;
      push_val_in   = push_val_ff;
      push_final_in = push_final_ff;
      window_in     = window_ff;
      prod_in       = prod_ff;
      divisor_in    = divisor_ff;
      drem_in       = drem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      alu_a         = ALU_W'(rem_ff);
      alu_b         = ALU_W'(ivl_eff);

      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_INTERVAL_TICKS)) begin
         interval_in = csr_pwdata[IVL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_time;
               amt_in   = req_amount;
               state_in = (req_op == OP_UPDATE) ? ST_U_START : ST_Q_SETUP;
            end
         end
         ST_U_START: begin
            rem_in = (now_ff >= last_ff) ? now_ff - last_ff : '0;
            if (upd_cnt_ff < CNT_FULL) begin
               upd_cnt_in = upd_cnt_ff + CNT_W'(1);
            end
            state_in = ST_U_ROLL;
         end
         ST_U_ROLL: begin
            if (alu_ge) begin
               // left over after the interval that closes now
               rem_in   = alu_diff[TIME_W-1:0];
               zcnt_in  = '0;
               state_in = ST_U_ZLOOP;
            end else begin
               current_in = acc_sum[VALUE_W] ? VALUE_MAX : acc_sum[VALUE_W-1:0];
               result_in  = previous_ff;
               state_in   = ST_OUT;
            end
         end
         ST_U_ZLOOP: begin
            if (alu_ge && (zcnt_ff < ZERO_MAX)) begin
               rem_in        = alu_diff[TIME_W-1:0];
               zcnt_in       = zcnt_ff + CNT_W'(1);
               push_val_in   = '0;
               push_final_in = 1'b0;
            end else begin
               push_val_in   = previous_ff;
               push_final_in = 1'b1;
            end
            state_in = ST_PUSH_RD;
         end
         ST_PUSH_RD: begin
            state_in = ST_PUSH_WR;
         end
         ST_PUSH_WR: begin
            ring_sum_in = ring_sum_ff - SUM_W'(old_slot) + SUM_W'(push_val_ff);
            slot_valid_in[widx_ff] = 1'b1;
            widx_in = (widx_ff == IDX_LAST) ? '0 : widx_ff + IDX_W'(1);
            if (push_final_ff) begin
               previous_in = current_ff;
               current_in  = VALUE_W'(amt_ff);
               last_in     = now_ff;
               result_in   = current_ff;
               state_in    = ST_OUT;
            end else begin
               state_in = ST_U_ZLOOP;
            end
         end
         ST_Q_SETUP: begin
            window_in = WIN_SLOTS * DIV_W'(ivl_eff);
            prod_in   = DIV_W'(upd_cnt_ff) * DIV_W'(ivl_eff);
            quo_in    = NUM_W'(previous_ff) + NUM_W'(ring_sum_ff);
            state_in  = ST_Q_CHECK;
         end
         ST_Q_CHECK: begin
            if (stale) begin
               result_in = '0;
               state_in  = ST_OUT;
            end else begin
               divisor_in = (div_sel == '0) ? DIV_W'(1) : div_sel;
               drem_in    = '0;
               dcnt_in    = DCNT_W'(NUM_W - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            alu_a  = ALU_W'(trial);
            alu_b  = ALU_W'(divisor_ff);
            drem_in = alu_ge ? alu_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in  = {quo_ff[NUM_W-2:0], alu_ge};
            if (dcnt_ff == '0) begin
               state_in = ST_DIV_END;
            end else begin
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end
         end
         ST_DIV_END: begin
            result_in = (quo_ff[NUM_W-1:VALUE_W] != '0) ? VALUE_MAX : quo_ff[VALUE_W-1:0];
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_INTERVAL_TICKS)
                       ? CSR_DATA_W'(interval_ff) : '0;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted transaction did not make the block busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result appeared outside the output step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      upd_cnt_ff <= CNT_FULL)
      else $error("update count beyond depth plus one");

   a_zero_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_U_ZLOOP) |-> (zcnt_ff <= ZERO_MAX))
      else $error("more zero slots than ring depth");

   a_write_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH_WR) |=> (widx_ff != $past(widx_ff) || SCORE_DEPTH == 1))
      else $error("ring write index did not advance");

endmodule

FILE: sim/rate_meter_checker.sv
`timescale 1ns / 1ps

module rate_meter_checker
   import wrm_pkg::*;
#(
   parameter int SCORE_DEPTH = SCORE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_op,
   input  logic [TIME_W-1:0]     req_now_time,
   input  logic [AMOUNT_W-1:0]   req_amount,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [VALUE_W-1:0]    rsp_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    results_seen,
   output int                    mismatches
);

   localparam int WIN_SLOTS = SCORE_DEPTH + 1;
   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = CSR_ADDR_W'(4 * REG_INTERVAL_TICKS);

   logic [IVL_W-1:0]   meter_ivl;
   logic [VALUE_W-1:0] cur_count;
   logic [VALUE_W-1:0] prev_count;
   logic [TIME_W-1:0]  roll_time;
   int unsigned        updates_seen;
   logic [VALUE_W-1:0] score_slots [SCORE_DEPTH];
   int unsigned        slot_ptr;
   logic [63:0]        slot_total;
   logic [VALUE_W-1:0] awaited_values [$];

   task automatic clear_meter();
      meter_ivl = IVL_W'(1);
      cur_count = '0;
      prev_count = '0;
      roll_time = '0;
      updates_seen = 0;
      for (int i = 0; i < SCORE_DEPTH; i++) score_slots[i] = '0;
      slot_ptr = 0;
      slot_total = '0;
   endtask

   task automatic push_slot(input logic [VALUE_W-1:0] v);
      slot_total = slot_total - 64'(score_slots[slot_ptr]) + 64'(v);
      score_slots[slot_ptr] = v;
      slot_ptr = (slot_ptr + 1) % SCORE_DEPTH;
   endtask

   // applies one transaction to the meter and returns the value it answers with
   task automatic advance_meter(input logic op, input logic [TIME_W-1:0] now,
                                input logic [AMOUNT_W-1:0] amt,
                                output logic [VALUE_W-1:0] answer);
      logic [63:0] ivl, elapsed, missed, window, divisor, quotient, sum, k;
      ivl = (meter_ivl == '0) ? 64'd1 : 64'(meter_ivl);
      if (op == OP_UPDATE) begin
         elapsed = (now >= roll_time) ? 64'(now) - 64'(roll_time) : 64'd0;
         if (updates_seen < WIN_SLOTS) updates_seen++;
         if (elapsed >= ivl) begin
            if (elapsed >= 2 * ivl) begin
               // one empty slot per skipped interval, never more than the ring holds
               missed = elapsed / ivl - 1;
               if (missed > 64'(SCORE_DEPTH)) missed = 64'(SCORE_DEPTH);
               for (k = 0; k < missed; k++) push_slot('0);
            end
            roll_time = now;
            push_slot(prev_count);
            prev_count = cur_count;
            cur_count = VALUE_W'(amt);
         end else begin
            sum = 64'(cur_count) + 64'(amt);
            cur_count = (sum > 64'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
         end
         answer = prev_count;
      end else begin
         window = 64'(WIN_SLOTS) * ivl;
         if (64'(now) > 64'(roll_time) + window) begin
            answer = '0;
         end else begin
            divisor = (updates_seen < WIN_SLOTS) ? 64'(updates_seen) * ivl : window;
            if (divisor == 0) divisor = 1;
            quotient = (64'(prev_count) + slot_total) / divisor;
            answer = (quotient > 64'(VALUE_MAX)) ? VALUE_MAX : quotient[VALUE_W-1:0];
         end
      end
   endtask

   always @(posedge clock) begin : watch
      logic [VALUE_W-1:0] want;
      if (reset) begin
         clear_meter();
         awaited_values.delete();
         results_seen <= 0;
         mismatches <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_values.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_value);
               mismatches <= mismatches + 1;
            end else begin
               want = awaited_values.pop_front();
               if (rsp_value !== want) begin
                  $display("%0t: value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_value);
                  mismatches <= mismatches + 1;
               end
            end
            results_seen <= results_seen + 1;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == INTERVAL_ADDR)
            meter_ivl = csr_pwdata[IVL_W-1:0];
         if (req_valid && !req_stall) begin
            advance_meter(req_op, req_now_time, req_amount, want);
            awaited_values.push_back(want);
         end
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench
   import wrm_pkg::*;
();

   localparam int CLK_HI = 6;
   localparam int CLK_LO = 6;
   localparam int RESET_CYCLES = 8;
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam int REG_SPARE_INDEX = 1;
   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = CSR_ADDR_W'(4 * REG_INTERVAL_TICKS);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * REG_SPARE_INDEX);
   localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = OP_UPDATE;
   logic [TIME_W-1:0]     req_now_time = '0;
   logic [AMOUNT_W-1:0]   req_amount = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int results_seen;
   int mismatches;
   int items_sent = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hold_go = 0;
   int hold_ack = 0;
   int hold_left = 0;
   longint cycles = 0;
   logic [TIME_W-1:0] tick_now = '0;
   logic [IVL_W-1:0]  ivl_set = IVL_W'(1);

   windowed_rate_meter_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_now_time (req_now_time),
      .req_amount   (req_amount),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   rate_meter_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_now_time (req_now_time),
      .req_amount   (req_amount),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .results_seen (results_seen),
      .mismatches   (mismatches)
   );

   always begin
      #(CLK_LO) clock = 1'b1;
      #(CLK_HI) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: a requested long hold-off wins over the random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go != hold_ack) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_ack <= hold_go;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == INTERVAL_ADDR) ivl_set = data[IVL_W-1:0];
   endtask

   task automatic offer(input logic op, input logic [TIME_W-1:0] t, input logic [AMOUNT_W-1:0] amt);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_now_time <= t;
      req_amount <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
   endtask

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(255);
         2: return AMOUNT_MAX;
         default: return '0;
      endcase
   endfunction

   // mostly well-formed update streams that roll over, plus queries and time going back
   task automatic random_traffic(input int count);
      logic [TIME_W-1:0] e, t, step;
      int kind;
      e = (ivl_set == '0) ? 32'd1 : 32'(ivl_set);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30) begin
            case ($urandom_range(3))
               0: t = tick_now;
               1: t = tick_now + $urandom_range(9 * e);
               2: t = tick_now + 9 * e + 1 + $urandom_range(4 * e);
               default: t = $urandom;
            endcase
            offer(OP_QUERY, t, pick_amount());
         end else begin
            kind = $urandom_range(9);
            case (kind)
               0, 1, 2: step = $urandom_range(e - 1);
               3, 4, 5: step = e + $urandom_range(e - 1);
               6, 7:    step = e * $urandom_range(2, 12) + $urandom_range(e - 1);
               8:       step = $urandom_range(32'h00FF_FFFF);
               default: step = '0;
            endcase
            if (kind == 9) begin
               t = tick_now - $urandom_range(3 * e);
            end else begin
               tick_now = tick_now + step;
               t = tick_now;
            end
            offer(OP_UPDATE, t, pick_amount());
         end
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] ivl, input int tx, input int rx,
                            input int count);
      wait_all();
      csr_write(INTERVAL_ADDR, ivl);
      tx_idle_pct = tx;
      rx_stall_pct = rx;
      random_traffic(count);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // interval of one out of reset, nothing counted yet
      offer(OP_QUERY, '0, AMOUNT_MAX);
      offer(OP_UPDATE, '0, AMOUNT_MAX);
      offer(OP_UPDATE, '0, AMOUNT_MAX);
      offer(OP_UPDATE, 32'd1, 32'd5);
      offer(OP_QUERY, 32'd1, '0);
      offer(OP_UPDATE, 32'd40, '0);
      offer(OP_QUERY, 32'd40, '0);
      offer(OP_QUERY, TIME_MAX, '0);
      offer(OP_UPDATE, 32'd3, 32'd7);
      offer(OP_UPDATE, 32'd42, 32'd1);
      offer(OP_QUERY, 32'd42, AMOUNT_MAX);
      wait_all();
      csr_write(SPARE_ADDR, 32'h0000_1234);
      csr_write(INTERVAL_ADDR, '0);
      offer(OP_UPDATE, 32'd50, 32'd100);
      offer(OP_UPDATE, 32'd51, 32'd200);
      offer(OP_QUERY, 32'd51, '0);
      wait_all();
      csr_write(INTERVAL_ADDR, '1);
      offer(OP_UPDATE, 32'h0001_0040, 32'd9);
      offer(OP_UPDATE, 32'h0009_0000, 32'h8000_0000);
      offer(OP_QUERY, 32'h0009_0000, '0);
      offer(OP_QUERY, 32'h0009_0000 + 9 * 32'hFFFF + 1, '0);
      tick_now = 32'h0009_0000;

      run_phase(32'd1, 0, 0, 60);
      run_phase(32'hFFFF, 85, 0, 60);
      run_phase('0, 0, 85, 60);

      // long hold-off on the result side while transactions keep coming
      wait_all();
      csr_write(INTERVAL_ADDR, $urandom_range(2, 300));
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_go++;
      random_traffic(20);
      tx_idle_pct = 14;
      rx_stall_pct = 14;
      random_traffic(55);

      run_phase($urandom_range(1, 20), 0, 0, 40);
      random_traffic(35);
      // sender pauses until the meter has answered everything
      run_phase($urandom_range(1, 65535), 14, 14, 35);
      wait_all();
      random_traffic(40);

      // time close to the top of its range, wrapping around
      wait_all();
      tick_now = 32'hFFF0_0000;
      run_phase($urandom_range(1, 4000), 14, 14, 50);
      offer(OP_UPDATE, TIME_MAX, 32'h8000_0000);
      offer(OP_QUERY, TIME_MAX, '0);
      offer(OP_UPDATE, TIME_MAX, 32'd1);
      offer(OP_QUERY, TIME_MAX, '0);

      wait_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_seen == items_sent) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/wrm_pkg.sv
design/wrm_ram.sv
design/windowed_rate_meter_unit.sv
sim/rate_meter_checker.sv
sim/testbench.sv
